@@ src/pgb_pkg.sv @@
// ----------------------------------------------------------------------------
// Point grid binning package
// Shared types and constants of the point grid binning core.
// ----------------------------------------------------------------------------
package pgb_pkg;

  localparam int unsigned IdW    = 20;
  localparam int unsigned LatW   = 31;
  localparam int unsigned LonW   = 32;
  localparam int unsigned EdgeW  = 32;
  localparam int unsigned DimW   = 7;
  localparam int unsigned RowOutW = 6;
  localparam int unsigned IdxOutW = 12;
  localparam int unsigned CntOutW = 16;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgAddrW-1:0] CfgOriginLat = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgOriginLon = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgCellEdge  = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgGridRows  = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgGridCols  = 3'd4;

  // Phases of the work on one item in the back part.
  typedef enum logic [2:0] {
    PhIdle, PhDiv, PhIndex, PhRead, PhUpd, PhOut, PhClear
  } ph_e;

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [DiffW-1:0] dlat;
    logic [DiffW-1:0] dlon;
    logic             below;
  } pgb_item_t;

endpackage

@@ src/pgb_front.sv @@
// ----------------------------------------------------------------------------
// Point grid binning front part
// Accepts points, forms the axis differences and flags points below the origin
// on either axis, then writes them into the queue.
// ----------------------------------------------------------------------------
module pgb_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [pgb_pkg::IdW-1:0]   point_id_i,
  input  logic [pgb_pkg::LatW-1:0]  latitude_i,
  input  logic [pgb_pkg::LonW-1:0]  longitude_i,
  input  logic [pgb_pkg::LatW-1:0]  origin_lat_i,
  input  logic [pgb_pkg::LonW-1:0]  origin_lon_i,
  output logic                      q_valid_o,
  input  logic                      q_stall_i,
  output pgb_pkg::pgb_item_t        q_item_o
);
  import pgb_pkg::*;

  logic      full_q, full_d;
  pgb_item_t item_q, item_d;
  logic signed [DiffW-1:0] dlat, dlon;

  assign dlat = DiffW'($signed(latitude_i)) - DiffW'($signed(origin_lat_i));
  assign dlon = DiffW'($signed(longitude_i)) - DiffW'($signed(origin_lon_i));

  assign in_stall  = full_q && q_stall_i;
  assign q_valid_o = full_q;
  assign q_item_o  = item_q;

  always_comb begin
    full_d = full_q;
    item_d = item_q;
    if (full_q && !q_stall_i) begin
      full_d = 1'b0;
    end
    if (in_valid && !in_stall) begin
      full_d       = 1'b1;
      item_d.id    = point_id_i;
      item_d.dlat  = dlat;
      item_d.dlon  = dlon;
      item_d.below = dlat[DiffW-1] || dlon[DiffW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

@@ src/pgb_queue.sv @@
// ----------------------------------------------------------------------------
// Point grid binning queue
// Two-entry queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module pgb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  output logic               wr_stall_o,
  input  pgb_pkg::pgb_item_t wr_item_i,
  output logic               rd_valid_o,
  input  logic               rd_stall_i,
  output pgb_pkg::pgb_item_t rd_item_o
);
  import pgb_pkg::*;

  pgb_item_t  mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       wr, rd;

  assign wr_stall_o = cnt_q == 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_item_o  = mem_q[rp_q];
  assign wr = wr_valid_i && !wr_stall_o;
  assign rd = rd_valid_o && !rd_stall_i;

  always_comb begin
    wp_d  = wr ? !wp_q : wp_q;
    rp_d  = rd ? !rp_q : rp_q;
    cnt_d = cnt_q + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_item_i;
    end
  end

endmodule

@@ src/pgb_back.sv @@
// ----------------------------------------------------------------------------
// Point grid binning back part
// Divides both axis differences by the cell edge one bit per cycle, clamps,
// forms the cell index and updates the histogram memory, which it clears after reset.
// ----------------------------------------------------------------------------
module pgb_back #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_stall_o,
  input  pgb_pkg::pgb_item_t          q_item_i,
  input  logic [pgb_pkg::EdgeW-1:0]   cell_edge_i,
  input  logic [pgb_pkg::DimW-1:0]    grid_rows_i,
  input  logic [pgb_pkg::DimW-1:0]    grid_cols_i,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pgb_pkg::IdW-1:0]     point_id_out_o,
  output logic [pgb_pkg::RowOutW-1:0] cell_row_o,
  output logic [pgb_pkg::RowOutW-1:0] cell_col_o,
  output logic [pgb_pkg::IdxOutW-1:0] cell_index_o,
  output logic [pgb_pkg::CntOutW-1:0] cell_count_o,
  output logic                        below_origin_o,
  output logic                        count_saturated_o
);
  import pgb_pkg::*;

  localparam int unsigned CellTotal = MAX_ROWS * MAX_COLS;
  localparam int unsigned IdxW  = (CellTotal > 1) ? $clog2(CellTotal) : 1;
  localparam int unsigned RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned DimCW = 11;
  localparam int unsigned QW    = DiffW - 1;
  localparam int unsigned StepW = $clog2(QW + 1);
  localparam int unsigned CntW  = $clog2(CellTotal + 1);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  ph_e                    ph_q, ph_d;
  logic [StepW-1:0]       step_q, step_d;
  logic [QW-1:0]          nlat_q, nlat_d, nlon_q, nlon_d;
  logic [EdgeW:0]         rlat_q, rlat_d, rlon_q, rlon_d;
  logic [IdW-1:0]         id_q, id_d;
  logic                   below_q, below_d, blat_q, blat_d, blon_q, blon_d;
  logic [RowW-1:0]        row_q, row_d;
  logic [ColW-1:0]        col_q, col_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d, rd_q;
  logic                   sat_q, sat_d;
  logic [CntW-1:0]        clr_q, clr_d;
  logic [COUNT_BITS-1:0]  hist_q [CellTotal];

  logic [EdgeW-1:0]  edge_v;
  logic [DimCW-1:0]  rows_v, cols_v;
  logic [EdgeW:0]    tlat, tlon;
  logic              mem_we;
  logic [IdxW-1:0]   mem_wa;
  logic [COUNT_BITS-1:0] mem_wd;
  logic [DimCW+ColW:0]   lin;

  always_comb begin
    edge_v = (cell_edge_i == '0) ? EdgeW'(1) : cell_edge_i;
    rows_v = (grid_rows_i == '0) ? DimCW'(1) : DimCW'(grid_rows_i);
    if (rows_v > DimCW'(MAX_ROWS)) rows_v = DimCW'(MAX_ROWS);
    cols_v = (grid_cols_i == '0) ? DimCW'(1) : DimCW'(grid_cols_i);
    if (cols_v > DimCW'(MAX_COLS)) cols_v = DimCW'(MAX_COLS);
    tlat = {rlat_q[EdgeW-1:0], nlat_q[QW-1]};
    tlon = {rlon_q[EdgeW-1:0], nlon_q[QW-1]};
  end

  assign q_stall_o = ph_q != PhIdle;
  assign lin = (DimCW + ColW + 1)'(row_q) * (DimCW + ColW + 1)'(cols_v)
             + (DimCW + ColW + 1)'(col_q);

  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      PhClear: begin
        if (clr_q == CntW'(CellTotal - 1)) ph_d = PhIdle;
      end
      PhIdle: begin
        if (q_valid_i) ph_d = PhDiv;
      end
      PhDiv: begin
        if (step_q == StepW'(QW - 1)) ph_d = PhIndex;
      end
      PhIndex: begin
        ph_d = PhRead;
      end
      PhRead: begin
        ph_d = PhUpd;
      end
      PhUpd: begin
        ph_d = PhOut;
      end
      PhOut: begin
        if (!out_stall) ph_d = PhIdle;
      end
      default: ph_d = PhIdle;
    endcase
  end

  always_comb begin
    step_d = step_q; nlat_d = nlat_q; nlon_d = nlon_q;
    rlat_d = rlat_q; rlon_d = rlon_q; id_d = id_q; below_d = below_q;
    blat_d = blat_q; blon_d = blon_q; row_d = row_q; col_d = col_q;
    idx_d = idx_q; cnt_d = cnt_q; sat_d = sat_q; clr_d = clr_q;
    mem_we = 1'b0; mem_wa = idx_q; mem_wd = cnt_q;
    case (ph_q)
      PhClear: begin
        mem_we = 1'b1;
        mem_wa = clr_q[IdxW-1:0];
        mem_wd = '0;
        clr_d  = clr_q + CntW'(1);
      end
      PhIdle: begin
        if (q_valid_i) begin
          id_d    = q_item_i.id;
          below_d = q_item_i.below;
          blat_d  = q_item_i.dlat[DiffW-1];
          blon_d  = q_item_i.dlon[DiffW-1];
          nlat_d  = q_item_i.dlat[QW-1:0];
          nlon_d  = q_item_i.dlon[QW-1:0];
          rlat_d  = '0;
          rlon_d  = '0;
          step_d  = '0;
        end
      end
      PhDiv: begin
        nlat_d = {nlat_q[QW-2:0], 1'b0};
        nlon_d = {nlon_q[QW-2:0], 1'b0};
        if (tlat >= {1'b0, edge_v}) begin
          rlat_d = tlat - {1'b0, edge_v};
          nlat_d[0] = 1'b1;
        end else begin
          rlat_d = tlat;
        end
        if (tlon >= {1'b0, edge_v}) begin
          rlon_d = tlon - {1'b0, edge_v};
          nlon_d[0] = 1'b1;
        end else begin
          rlon_d = tlon;
        end
        step_d = step_q + StepW'(1);
      end
      PhIndex: begin
        if (blat_q) row_d = '0;
        else if (nlat_q >= QW'(rows_v)) row_d = RowW'(rows_v - DimCW'(1));
        else row_d = nlat_q[RowW-1:0];
        if (blon_q) col_d = '0;
        else if (nlon_q >= QW'(cols_v)) col_d = ColW'(cols_v - DimCW'(1));
        else col_d = nlon_q[ColW-1:0];
      end
      PhRead: begin
        if (lin >= (DimCW + ColW + 1)'(CellTotal)) idx_d = IdxW'(CellTotal - 1);
        else idx_d = lin[IdxW-1:0];
      end
      PhUpd: begin
        sat_d  = rd_q == CountMax;
        cnt_d  = (rd_q == CountMax) ? rd_q : rd_q + COUNT_BITS'(1);
        mem_we = 1'b1;
        mem_wd = cnt_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PhClear;
      clr_q <= '0;
    end else begin
      ph_q  <= ph_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d; nlat_q <= nlat_d; nlon_q <= nlon_d;
    rlat_q <= rlat_d; rlon_q <= rlon_d; id_q <= id_d; below_q <= below_d;
    blat_q <= blat_d; blon_q <= blon_d; row_q <= row_d; col_q <= col_d;
    idx_q <= idx_d; cnt_q <= cnt_d; sat_q <= sat_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_q[mem_wa] <= mem_wd;
    end
    rd_q <= hist_q[idx_d];
  end

  assign out_valid         = ph_q == PhOut;
  assign point_id_out_o    = id_q;
  assign cell_row_o        = RowOutW'(row_q);
  assign cell_col_o        = RowOutW'(col_q);
  assign cell_index_o      = IdxOutW'(idx_q);
  assign cell_count_o      = CntOutW'(cnt_q);
  assign below_origin_o    = below_q;
  assign count_saturated_o = sat_q;

endmodule

@@ src/point_grid_binning_core.sv @@
// ----------------------------------------------------------------------------
// Point grid binning core
// Bins geographic points into a uniform grid and keeps a per-cell histogram.
//
//   Channel  Direction  Handshake
//   input    in         in_valid / in_stall
//   output   out        out_valid / out_stall
//   config   in         cfg_we_i, cfg_idx_i, cfg_data_i
//
// In the back part an item is taken from the queue, then both axes go
// through bit-serial division in parallel, then index, memory read, update
// and a result transfer. After reset the histogram is cleared, during which
// the back part takes no point from the queue. Either side may stall at any
// time.
// ----------------------------------------------------------------------------
module point_grid_binning_core #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pgb_pkg::CfgAddrW-1:0]  cfg_idx_i,
  input  logic [pgb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pgb_pkg::IdW-1:0]       point_id_i,
  input  logic [pgb_pkg::LatW-1:0]      latitude_i,
  input  logic [pgb_pkg::LonW-1:0]      longitude_i,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pgb_pkg::IdW-1:0]       point_id_out_o,
  output logic [pgb_pkg::RowOutW-1:0]   cell_row_o,
  output logic [pgb_pkg::RowOutW-1:0]   cell_col_o,
  output logic [pgb_pkg::IdxOutW-1:0]   cell_index_o,
  output logic [pgb_pkg::CntOutW-1:0]   cell_count_o,
  output logic                          below_origin_o,
  output logic                          count_saturated_o
);
  import pgb_pkg::*;

  logic [LatW-1:0]  olat_q;
  logic [LonW-1:0]  olon_q;
  logic [EdgeW-1:0] edge_q;
  logic [DimW-1:0]  rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      olat_q <= '0;
      olon_q <= '0;
      edge_q <= EdgeW'(1);
      rows_q <= DimW'(1);
      cols_q <= DimW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOriginLat: olat_q <= cfg_data_i[LatW-1:0];
        CfgOriginLon: olon_q <= cfg_data_i[LonW-1:0];
        CfgCellEdge:  edge_q <= cfg_data_i[EdgeW-1:0];
        CfgGridRows:  rows_q <= cfg_data_i[DimW-1:0];
        CfgGridCols:  cols_q <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  logic      fq_valid, fq_stall, bq_valid, bq_stall;
  pgb_item_t fq_item, bq_item;

  pgb_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .point_id_i, .latitude_i,
    .longitude_i, .origin_lat_i(olat_q), .origin_lon_i(olon_q),
    .q_valid_o(fq_valid), .q_stall_i(fq_stall), .q_item_o(fq_item)
  );

  pgb_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fq_valid), .wr_stall_o(fq_stall),
    .wr_item_i(fq_item), .rd_valid_o(bq_valid), .rd_stall_i(bq_stall),
    .rd_item_o(bq_item)
  );

  pgb_back #(
    .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i, .rst_ni, .q_valid_i(bq_valid), .q_stall_o(bq_stall),
    .q_item_i(bq_item), .cell_edge_i(edge_q), .grid_rows_i(rows_q),
    .grid_cols_i(cols_q), .out_valid, .out_stall, .point_id_out_o,
    .cell_row_o, .cell_col_o, .cell_index_o, .cell_count_o,
    .below_origin_o, .count_saturated_o
  );

endmodule

@@ tb/point_grid_binning_core_tb.sv @@
// ----------------------------------------------------------------------------
// Point grid binning core testbench
// Streams geographic points into the core under a series of grid settings,
// predicts row, column, cell index and histogram count for every accepted
// point and compares each result transfer with the oldest prediction. A short
// directed table covers the field extremes and special cases, then random points
// cluster around the grid, with no random gaps or stalls in grids 3, 6 and 8.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module point_grid_binning_core_tb;
  import pgb_pkg::*;

  localparam int unsigned GridRowsMax = 64;
  localparam int unsigned GridColsMax = 64;
  localparam int unsigned CellTotal   = GridRowsMax * GridColsMax;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned DrainCycles = 60;

  typedef struct {
    logic [IdW-1:0]     id;
    logic [RowOutW-1:0] row;
    logic [RowOutW-1:0] col;
    logic [IdxOutW-1:0] idx;
    logic [CntOutW-1:0] cnt;
    logic               below;
    logic               sat;
  } bin_result_t;

  typedef struct {
    longint          olat;
    longint          olon;
    longint unsigned edge_len;
    int unsigned     rows;
    int unsigned     cols;
  } grid_cfg_t;

  typedef struct {
    int           grid;
    logic [19:0]  id;
    longint       lat;
    longint       lon;
    bit           typed;
    logic [15:0]  cnt;
    bit           below;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [IdW-1:0]      point_id_i = '0;
  logic [LatW-1:0]     latitude_i = '0;
  logic [LonW-1:0]     longitude_i = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [IdW-1:0]      point_id_out_o;
  logic [RowOutW-1:0]  cell_row_o;
  logic [RowOutW-1:0]  cell_col_o;
  logic [IdxOutW-1:0]  cell_index_o;
  logic [CntOutW-1:0]  cell_count_o;
  logic                below_origin_o;
  logic                count_saturated_o;

  point_grid_binning_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid, .in_stall, .point_id_i, .latitude_i, .longitude_i,
    .out_valid, .out_stall, .point_id_out_o, .cell_row_o, .cell_col_o,
    .cell_index_o, .cell_count_o, .below_origin_o, .count_saturated_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  longint          org_lat = 0;
  longint          org_lon = 0;
  longint unsigned edge_reg = 1;
  int unsigned     rows_reg = 1;
  int unsigned     cols_reg = 1;
  logic [15:0]     cell_hits [CellTotal];
  bin_result_t     pending_bins[$];
  int unsigned     errors = 0;
  bit              idle_en = 1'b1;
  int unsigned     stall_left = 0;
  int unsigned     quiet_cycles = 0;

  function automatic int unsigned eff_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic longint unsigned axis_bin(longint pos, longint origin,
                                               longint unsigned e,
                                               int unsigned lim, inout logic below);
    longint d;
    longint unsigned q;
    d = pos - origin;
    if (d < 0) begin
      below = 1'b1;
      return 0;
    end
    q = longint'(d) / e;
    if (q > lim - 1) q = lim - 1;
    return q;
  endfunction

  function automatic bin_result_t bin_point(logic [19:0] id, longint lat, longint lon);
    bin_result_t res;
    longint unsigned e, r, c, ix;
    int unsigned nr, nc;
    e = (edge_reg == 0) ? 1 : edge_reg;
    nr = eff_dim(rows_reg, GridRowsMax);
    nc = eff_dim(cols_reg, GridColsMax);
    res.below = 1'b0;
    res.sat = 1'b0;
    r = axis_bin(lat, org_lat, e, nr, res.below);
    c = axis_bin(lon, org_lon, e, nc, res.below);
    ix = r * nc + c;
    if (ix >= CellTotal) ix = CellTotal - 1;
    if (cell_hits[ix] == 16'hFFFF) res.sat = 1'b1;
    else cell_hits[ix] = cell_hits[ix] + 1;
    res.id = id;
    res.row = r[5:0];
    res.col = c[5:0];
    res.idx = ix[11:0];
    res.cnt = cell_hits[ix];
    return res;
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    bin_result_t exp_r;
    if (out_valid && !out_stall) begin
      if (pending_bins.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected, id %0d", $time,
                 point_id_out_o);
      end else begin
        exp_r = pending_bins.pop_front();
        check_field("point_id", exp_r.id, point_id_out_o);
        check_field("cell_row", exp_r.row, cell_row_o);
        check_field("cell_col", exp_r.col, cell_col_o);
        check_field("cell_index", exp_r.idx, cell_index_o);
        check_field("cell_count", exp_r.cnt, cell_count_o);
        check_field("below_origin", exp_r.below, below_origin_o);
        check_field("count_saturated", exp_r.sat, count_saturated_o);
      end
    end
    if (stall_left > 0) stall_left--;
    else if (idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 6);
    out_stall <= (stall_left > 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_point(input logic [19:0] id, input longint lat, input longint lon,
                            input bit typed, input bin_result_t typed_r);
    bin_result_t r;
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    point_id_i <= id;
    latitude_i <= lat[30:0];
    longitude_i <= lon[31:0];
    do @(posedge clk_i); while (in_stall);
    r = bin_point(id, lat, lon);
    pending_bins.insert(pending_bins.size(), typed ? typed_r : r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic apply_grid(input grid_cfg_t g);
    logic [31:0] d [5];
    logic [CfgAddrW-1:0] a [5];
    drain();
    a = '{CfgOriginLat, CfgOriginLon, CfgCellEdge, CfgGridRows, CfgGridCols};
    d = '{g.olat[31:0], g.olon[31:0], g.edge_len[31:0], g.rows, g.cols};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= a[i];
      cfg_data_i <= d[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    org_lat = longint'($signed(d[0][30:0]));
    org_lon = longint'($signed(d[1]));
    edge_reg = d[2];
    rows_reg = d[3][6:0];
    cols_reg = d[4][6:0];
  endtask

  function automatic longint near_axis(longint origin, int unsigned n, longint lo,
                                       longint hi);
    longint unsigned e, span;
    longint v;
    e = (edge_reg == 0) ? 1 : edge_reg;
    span = e * (eff_dim(n, 64) + 2);
    if (span > 2000000000) span = 2000000000;
    if ($urandom_range(0, 7) == 0) v = longint'($urandom_range(0, hi - lo)) + lo;
    else v = origin + longint'($urandom_range(0, span)) - longint'(e);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  grid_cfg_t grids [5] = '{
    '{0, 0, 1, 1, 1},
    '{-100, -200, 10, 4, 5},
    '{0, 0, 0, 0, 0},
    '{0, 0, 1, 127, 127},
    '{900000000, -1800000000, 64'd3600000000, 64, 64}
  };

  dir_row_t dir_rows [] = '{
    '{0, 20'h00000, 0, 0, 1, 1, 0},
    '{0, 20'hFFFFF, 900000000, 1800000000, 1, 2, 0},
    '{0, 20'h12345, -900000000, 0, 1, 3, 1},
    '{0, 20'h00001, 0, -1800000000, 1, 4, 1},
    '{0, 20'h00002, -1, -1, 1, 5, 1},
    '{1, 20'h00010, -100, -200, 0, 0, 0},
    '{1, 20'h00011, -101, -150, 0, 0, 0},
    '{1, 20'h00012, -91, -191, 0, 0, 0},
    '{1, 20'h00013, -61, -151, 0, 0, 0},
    '{1, 20'h00014, 900000000, 1800000000, 0, 0, 0},
    '{1, 20'h00015, -50, -300, 0, 0, 0},
    '{2, 20'h00020, 5, 7, 0, 0, 0},
    '{2, 20'h00021, -5, 7, 0, 0, 0},
    '{3, 20'h00030, 63, 63, 0, 0, 0},
    '{3, 20'h00031, 100, 100, 0, 0, 0},
    '{3, 20'h00032, 1, 62, 0, 0, 0},
    '{4, 20'h00040, 899999999, -1800000000, 0, 0, 0},
    '{4, 20'h00041, -900000000, 1800000000, 0, 0, 0}
  };

  initial begin
    grid_cfg_t g;
    bin_result_t t;
    int cur_grid;
    longint lat, lon;
    for (int i = 0; i < CellTotal; i++) cell_hits[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_grid = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].grid != cur_grid) begin
        cur_grid = dir_rows[i].grid;
        apply_grid(grids[cur_grid]);
      end
      t = '{dir_rows[i].id, 0, 0, 0, dir_rows[i].cnt, dir_rows[i].below, 0};
      send_point(dir_rows[i].id, dir_rows[i].lat, dir_rows[i].lon, dir_rows[i].typed, t);
    end

    for (int p = 0; p < 8; p++) begin
      if (p < 5) g = grids[p];
      else begin
        g.olat = longint'($urandom_range(0, 1800000000)) - 900000000;
        g.olon = longint'($urandom_range(0, 2000000000)) - 1000000000;
        g.edge_len = ($urandom_range(0, 1)) ? $urandom_range(1, 100)
                                            : $urandom_range(1, 20000000);
        g.rows = $urandom_range(0, 127);
        g.cols = $urandom_range(0, 127);
      end
      apply_grid(g);
      idle_en = (p < 7) && (p % 3 != 2);
      for (int k = 0; k < 120; k++) begin
        if (k % 40 == 39) drain();
        lat = near_axis(org_lat, rows_reg, -900000000, 900000000);
        lon = near_axis(org_lon, cols_reg, -1800000000, 1800000000);
        send_point(20'($urandom_range(0, 20'hFFFFF)), lat, lon, 1'b0, t);
      end
    end

    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
src/pgb_pkg.sv
src/pgb_front.sv
src/pgb_queue.sv
src/pgb_back.sv
src/point_grid_binning_core.sv
tb/point_grid_binning_core_tb.sv
